@@ rtl/rstd_pkg.sv @@
// Shared types and constants for the RSI slope trend direction block.
package rstd_pkg;

  localparam int RSI_W     = 23;
  localparam int SLOPE_W   = RSI_W + 1;
  localparam int WEIGHT_W  = 17;
  localparam int FRAC_BITS = 16;
  localparam int DIR_W     = 2;
  localparam int LEN_CFG_W = 5;
  localparam int THR_W     = 23;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 23;

  localparam int RSI_SCALE  = 100;
  localparam int ROUND_HALF = 32768;

  localparam logic [RSI_W-1:0]    RSI_FULL   = 23'd6553600;
  localparam logic [RSI_W-1:0]    RSI_HALF   = 23'd3276800;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 17'd21845;
  localparam logic [LEN_CFG_W-1:0] LEN_RST   = 5'd10;
  localparam logic [THR_W-1:0]    THR_RST    = 23'd19661;

  localparam logic signed [DIR_W-1:0] DIR_UP   = 2'sb01;
  localparam logic signed [DIR_W-1:0] DIR_DOWN = 2'sb11;
  localparam logic signed [DIR_W-1:0] DIR_FLAT = 2'sb00;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH   = 2'd0,
    CFG_EMA_WEIGHT      = 2'd1,
    CFG_TREND_THRESHOLD = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_RSI,
    ST_DIV,
    ST_SLOPE,
    ST_MUL,
    ST_RESULT
  } state_t;

endpackage

@@ rtl/rsi_slope_trend_direction_top.sv @@
// RSI slope trend direction: windowed gain/loss sums, serial RSI divide, slope average.
//
//   channel | handshake                 | payload
//   --------+---------------------------+-------------------------------------------
//   in      | in_valid / in_stall       | price
//   out     | out_valid / out_stall     | trend_direction, rsi_value, smoothed_slope, warmed
//   cfg     | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// First sample after reset: price latched only. Window not yet full: sums updated only.
// Full window: RSI divide, then slope; once warm also the average update (23-step serial
// divider, 17-step serial weight multiplier); no divide when the loss sum is zero.
// One item at a time; in_stall is high from the transfer until the result is
// loaded into the output register. A stalled output holds only a finished result.
// Reset (rst, synchronous) needs no clearing pass; cfg_ready is always high.
module rsi_slope_trend_direction_top #(
  parameter int MAX_WINDOW = 16,
  parameter int PRICE_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [31:0]                            price,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [rstd_pkg::DIR_W-1:0]      trend_direction,
  output logic [rstd_pkg::RSI_W-1:0]             rsi_value,
  output logic signed [rstd_pkg::SLOPE_W-1:0]    smoothed_slope,
  output logic                                   warmed,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [rstd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [rstd_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import rstd_pkg::*;

  localparam int PW      = (PRICE_BITS < 32) ? PRICE_BITS : 32;
  localparam int AW      = $clog2(MAX_WINDOW);
  localparam int LEN_W   = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W   = PW + AW;
  localparam int DELTA_W = SLOPE_W + 1;
  localparam int PRW     = DELTA_W + WEIGHT_W;

  state_t state;
  state_t state_next;

  logic [LEN_CFG_W-1:0]      window_length;
  logic [WEIGHT_W-1:0]       ema_weight;
  logic [THR_W-1:0]          trend_threshold;

  logic [PW-1:0]             last_price;
  logic                      have_last;
  logic [PW-1:0]             gain;
  logic [PW-1:0]             loss;
  logic [LEN_W-1:0]          fill;
  logic [AW-1:0]             pointer;
  logic [SUM_W-1:0]          gain_sum;
  logic [SUM_W-1:0]          loss_sum;
  logic [RSI_W-1:0]          rsi_current;
  logic [RSI_W-1:0]          rsi_previous;
  logic signed [SLOPE_W-1:0] slope_average;
  logic                      is_warmed;

  logic                      accept;
  logic                      load_out;
  logic                      div_start;
  logic                      mul_start;
  logic                      rsi_full_set;
  logic                      div_done;
  logic                      mul_done;
  logic [RSI_W-1:0]          div_q;
  logic signed [PRW-1:0]     prod;

  logic [PW-1:0]             price_m;
  logic [LEN_W-1:0]          act_len;
  logic                      full;
  logic                      full_after;
  logic [LEN_W-1:0]          fill_inc;
  logic [LEN_W-1:0]          ptr_inc;
  logic [2*PW-1:0]           ram_rdata;
  logic [PW-1:0]             old_gain;
  logic [PW-1:0]             old_loss;
  logic signed [SLOPE_W-1:0] slope;
  logic signed [DELTA_W-1:0] delta;
  logic signed [PRW-1:0]     rounded;
  logic [WEIGHT_W-1:0]       weight_eff;
  logic signed [DELTA_W-1:0] avg_x;
  logic signed [DELTA_W-1:0] thr_x;
  logic signed [DIR_W-1:0]   dir;

  assign cfg_ready = 1'b1;

  always_comb begin
    price_m = price[PW-1:0];
    if (window_length == '0) begin
      act_len = LEN_W'(1);
    end else if (int'(window_length) > MAX_WINDOW) begin
      act_len = LEN_W'(MAX_WINDOW);
    end else begin
      act_len = LEN_W'(window_length);
    end
    full       = (fill >= act_len);
    fill_inc   = fill + 1'b1;
    full_after = full || (fill_inc >= act_len);
    ptr_inc    = LEN_W'(pointer) + 1'b1;
    old_gain   = ram_rdata[2*PW-1:PW];
    old_loss   = ram_rdata[PW-1:0];
    slope      = $signed({1'b0, rsi_current}) - $signed({1'b0, rsi_previous});
    delta      = {slope[SLOPE_W-1], slope} - {slope_average[SLOPE_W-1], slope_average};
    rounded    = (prod + $signed(PRW'(ROUND_HALF))) >>> FRAC_BITS;
    weight_eff = ema_weight[WEIGHT_W-1] ? WEIGHT_ONE : ema_weight;
    avg_x      = {slope_average[SLOPE_W-1], slope_average};
    thr_x      = $signed({2'b00, trend_threshold});
    dir        = DIR_FLAT;
    if (is_warmed && (avg_x > thr_x)) begin
      dir = DIR_UP;
    end else if (is_warmed && (avg_x < -thr_x)) begin
      dir = DIR_DOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_stall     = (state != ST_IDLE);
    accept       = 1'b0;
    load_out     = 1'b0;
    div_start    = 1'b0;
    mul_start    = 1'b0;
    rsi_full_set = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          accept     = 1'b1;
          state_next = have_last ? ST_UPDATE : ST_RESULT;
        end
      end
      ST_UPDATE: begin
        state_next = full_after ? ST_RSI : ST_RESULT;
      end
      ST_RSI: begin
        if (loss_sum == '0) begin
          rsi_full_set = 1'b1;
          state_next   = ST_SLOPE;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_SLOPE;
        end
      end
      ST_SLOPE: begin
        if (is_warmed) begin
          mul_start  = 1'b1;
          state_next = ST_MUL;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  rstd_ram #(
    .WIDTH(2 * PW),
    .DEPTH(MAX_WINDOW)
  ) u_window (
    .clk  (clk),
    .we   (state == ST_UPDATE),
    .waddr(pointer),
    .wdata({gain, loss}),
    .raddr(pointer),
    .rdata(ram_rdata)
  );

  rstd_div #(
    .SUM_W(SUM_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .gain_sum(gain_sum),
    .loss_sum(loss_sum),
    .done    (div_done),
    .quotient(div_q)
  );

  rstd_mul #(
    .DW(DELTA_W)
  ) u_mul (
    .clk         (clk),
    .rst         (rst),
    .start       (mul_start),
    .multiplicand(delta),
    .weight      (weight_eff),
    .done        (mul_done),
    .product     (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length   <= LEN_RST;
      ema_weight      <= WEIGHT_RST;
      trend_threshold <= THR_RST;
      have_last       <= 1'b0;
      last_price      <= '0;
      fill            <= '0;
      pointer         <= '0;
      gain_sum        <= '0;
      loss_sum        <= '0;
      rsi_current     <= RSI_HALF;
      rsi_previous    <= RSI_HALF;
      slope_average   <= '0;
      is_warmed       <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WINDOW_LENGTH: begin
            window_length <= cfg_data[LEN_CFG_W-1:0];
            fill          <= '0;
            pointer       <= '0;
            gain_sum      <= '0;
            loss_sum      <= '0;
          end
          CFG_EMA_WEIGHT: begin
            ema_weight <= cfg_data[WEIGHT_W-1:0];
          end
          CFG_TREND_THRESHOLD: begin
            trend_threshold <= cfg_data[THR_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (accept) begin
        have_last  <= 1'b1;
        last_price <= price_m;
      end
      if (state == ST_UPDATE) begin
        gain_sum <= gain_sum + SUM_W'(gain) - (full ? SUM_W'(old_gain) : '0);
        loss_sum <= loss_sum + SUM_W'(loss) - (full ? SUM_W'(old_loss) : '0);
        if (!full) begin
          fill <= fill_inc;
        end
        pointer <= (ptr_inc == act_len) ? '0 : AW'(ptr_inc);
      end
      if (rsi_full_set) begin
        rsi_previous <= rsi_current;
        rsi_current  <= RSI_FULL;
      end else if (div_done) begin
        rsi_previous <= rsi_current;
        rsi_current  <= div_q;
      end
      if ((state == ST_SLOPE) && !is_warmed) begin
        slope_average <= slope;
        is_warmed     <= 1'b1;
      end else if (mul_done) begin
        slope_average <= slope_average + rounded[SLOPE_W-1:0];
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      gain <= (price_m > last_price) ? price_m - last_price : '0;
      loss <= (price_m < last_price) ? last_price - price_m : '0;
    end
    if (load_out) begin
      trend_direction <= dir;
      rsi_value       <= rsi_current;
      smoothed_slope  <= slope_average;
      warmed          <= is_warmed;
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= act_len)
    else $error("window fill beyond active length");

  a_rsi_range: assert property (@(posedge clk) disable iff (rst)
    div_done |=> rsi_current <= RSI_FULL)
    else $error("divider result above full scale");

  a_warm_from_slope: assert property (@(posedge clk) disable iff (rst)
    $rose(is_warmed) |-> $past(state) == ST_SLOPE)
    else $error("average warmed outside the slope step");

  a_mul_warm: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> is_warmed)
    else $error("average update started before warm-up");
`endif

endmodule

@@ rtl/rstd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rstd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/rstd_div.sv @@
// Bit-serial restoring divider for RSI = 6553600 * G / (G + L).
module rstd_div #(
  parameter int SUM_W = 36
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [SUM_W-1:0]          gain_sum,
  input  logic [SUM_W-1:0]          loss_sum,
  output logic                      done,
  output logic [rstd_pkg::RSI_W-1:0] quotient
);
  import rstd_pkg::*;

  localparam int MW = SUM_W + 7;
  localparam int SH = RSI_W - FRAC_BITS;
  localparam int CW = $clog2(RSI_W);

  logic              busy;
  logic [CW-1:0]     count;
  logic [SUM_W:0]    divisor;
  logic [SUM_W:0]    rem;
  logic [RSI_W-1:0]  feed;
  logic [RSI_W-1:0]  quo;

  logic [MW-1:0]     scaled;
  logic [SUM_W+1:0]  trial;
  logic [SUM_W+2:0]  diff;
  logic              fits;
  logic [SUM_W:0]    rem_next;

  always_comb begin
    scaled   = MW'(gain_sum) * MW'(RSI_SCALE);
    trial    = {rem, feed[RSI_W-1]};
    diff     = {1'b0, trial} - {2'b00, divisor};
    fits     = !diff[SUM_W+2];
    rem_next = fits ? diff[SUM_W:0] : trial[SUM_W:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(RSI_W - 1);
      end else if (busy) begin
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      divisor <= {1'b0, gain_sum} + {1'b0, loss_sum};
      rem     <= (SUM_W+1)'(scaled >> SH);
      feed    <= {scaled[SH-1:0], {FRAC_BITS{1'b0}}};
      quo     <= '0;
    end else if (busy) begin
      rem  <= rem_next;
      feed <= {feed[RSI_W-2:0], 1'b0};
      quo  <= {quo[RSI_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

@@ rtl/rstd_mul.sv @@
// Bit-serial signed by unsigned multiplier, one weight bit per cycle, MSB first.
module rstd_mul #(
  parameter int DW = 25
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic signed [DW-1:0]                    multiplicand,
  input  logic [rstd_pkg::WEIGHT_W-1:0]           weight,
  output logic                                    done,
  output logic signed [DW+rstd_pkg::WEIGHT_W-1:0] product
);
  import rstd_pkg::*;

  localparam int PRW = DW + WEIGHT_W;
  localparam int CW  = $clog2(WEIGHT_W);

  logic                  busy;
  logic [CW-1:0]         count;
  logic signed [PRW-1:0] mcand;
  logic [WEIGHT_W-1:0]   mplier;
  logic signed [PRW-1:0] acc;
  logic signed [PRW-1:0] acc_next;

  always_comb begin
    acc_next = (acc <<< 1) + (mplier[WEIGHT_W-1] ? mcand : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(WEIGHT_W - 1);
      end else if (busy) begin
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= {{WEIGHT_W{multiplicand[DW-1]}}, multiplicand};
      mplier <= weight;
      acc    <= '0;
    end else if (busy) begin
      acc    <= acc_next;
      mplier <= {mplier[WEIGHT_W-2:0], 1'b0};
    end
  end

  assign product = acc;

endmodule

@@ bench/rsi_trend_checker.sv @@
// Checker for the RSI slope trend block: predicts each result and compares it field by field.
module rsi_trend_checker #(
  parameter int MAX_WINDOW = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [31:0]                         price,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [rstd_pkg::DIR_W-1:0]   trend_direction,
  input  logic [rstd_pkg::RSI_W-1:0]          rsi_value,
  input  logic signed [rstd_pkg::SLOPE_W-1:0] smoothed_slope,
  input  logic                                warmed,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [rstd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rstd_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                  mismatches,
  output int                                  outstanding,
  output int                                  compared
);
  timeunit 1ns;
  timeprecision 1ps;

  import rstd_pkg::*;

  typedef struct {
    logic signed [DIR_W-1:0]   dir;
    logic [RSI_W-1:0]          rsi;
    logic signed [SLOPE_W-1:0] slope;
    logic                      warm;
  } trend_t;

  trend_t trend_due[$];

  logic [LEN_CFG_W-1:0] len_cfg;
  logic [WEIGHT_W-1:0]  weight_cfg;
  logic [THR_W-1:0]     thr_cfg;

  logic [31:0]     last_px;
  bit              have_px;
  logic [31:0]     gain_win [MAX_WINDOW];
  logic [31:0]     loss_win [MAX_WINDOW];
  int              fill;
  int              ptr;
  longint unsigned gain_total;
  longint unsigned loss_total;
  longint          rsi_cur;
  longint          rsi_last;
  longint          slope_avg;
  bit              warm;

  task automatic restart_window();
    fill = 0;
    ptr = 0;
    gain_total = 0;
    loss_total = 0;
  endtask

  task automatic reset_model();
    len_cfg = LEN_RST;
    weight_cfg = WEIGHT_RST;
    thr_cfg = THR_RST;
    last_px = '0;
    have_px = 1'b0;
    restart_window();
    rsi_cur = longint'(RSI_HALF);
    rsi_last = longint'(RSI_HALF);
    slope_avg = 0;
    warm = 1'b0;
  endtask

  function automatic trend_t next_trend(input logic [31:0] px);
    trend_t r;
    int span;
    int slot;
    logic [31:0] gain;
    logic [31:0] loss;
    longint slope;
    longint w;
    longint adj;
    longint unsigned num;
    if (!have_px) begin
      last_px = px;
      have_px = 1'b1;
    end else begin
      span = (len_cfg == 0) ? 1 : (int'(len_cfg) > MAX_WINDOW) ? MAX_WINDOW : int'(len_cfg);
      gain = (px > last_px) ? px - last_px : '0;
      loss = (px < last_px) ? last_px - px : '0;
      slot = ptr % span;
      last_px = px;
      if (fill >= span) begin
        gain_total -= gain_win[slot];
        loss_total -= loss_win[slot];
      end else begin
        fill++;
      end
      gain_win[slot] = gain;
      loss_win[slot] = loss;
      gain_total += gain;
      loss_total += loss;
      ptr = (slot + 1) % span;
      if (fill >= span) begin
        w = (weight_cfg > WEIGHT_ONE) ? 65536 : longint'(weight_cfg);
        rsi_last = rsi_cur;
        if (loss_total == 0) begin
          rsi_cur = longint'(RSI_FULL);
        end else begin
          num = 64'd6553600 * gain_total;
          rsi_cur = longint'(num / (gain_total + loss_total));
        end
        slope = rsi_cur - rsi_last;
        if (!warm) begin
          slope_avg = slope;
          warm = 1'b1;
        end else begin
          adj = (slope - slope_avg) * w + 32768;
          slope_avg += adj >>> 16;
        end
      end
    end
    r.dir = DIR_FLAT;
    if (warm) begin
      if (slope_avg > longint'(thr_cfg)) r.dir = DIR_UP;
      else if (slope_avg < -longint'(thr_cfg)) r.dir = DIR_DOWN;
    end
    r.rsi = rsi_cur[RSI_W-1:0];
    r.slope = slope_avg[SLOPE_W-1:0];
    r.warm = warm;
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    if (mismatches < 40) begin
      $display("mismatch at result %0d: %s got %0d expected %0d", compared, what, got, want);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    trend_t want;
    if (rst) begin
      reset_model();
      trend_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WINDOW_LENGTH: begin
            len_cfg = cfg_data[LEN_CFG_W-1:0];
            restart_window();
          end
          CFG_EMA_WEIGHT:      weight_cfg = cfg_data[WEIGHT_W-1:0];
          CFG_TREND_THRESHOLD: thr_cfg = cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (trend_due.size() == 0) begin
          report("result with nothing pending, rsi_value", longint'(rsi_value), 0);
        end else begin
          want = trend_due[0];
          trend_due.delete(0);
          if (trend_direction !== want.dir)
            report("trend_direction", longint'(trend_direction), longint'(want.dir));
          if (rsi_value !== want.rsi)
            report("rsi_value", longint'(rsi_value), longint'(want.rsi));
          if (smoothed_slope !== want.slope)
            report("smoothed_slope", longint'(smoothed_slope), longint'(want.slope));
          if (warmed !== want.warm)
            report("warmed", longint'(warmed), longint'(want.warm));
        end
        compared++;
      end
      if (in_valid && !in_stall) begin
        trend_due.insert(trend_due.size(), next_trend(price));
      end
    end
    outstanding <= trend_due.size();
  end

endmodule

@@ bench/rsi_slope_trend_direction_top_tb.sv @@
// Testbench top for the RSI slope trend block: clock, reset, stimulus and verdict.
module rsi_slope_trend_direction_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rstd_pkg::*;

  localparam int MAX_WINDOW  = 16;
  localparam int ITEMS       = 1700;
  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD   = 300;
  localparam int TAIL        = 60;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [31:0]               price = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [DIR_W-1:0]   trend_direction;
  logic [RSI_W-1:0]          rsi_value;
  logic signed [SLOPE_W-1:0] smoothed_slope;
  logic                      warmed;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = CFG_WINDOW_LENGTH;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  int mismatches;
  int outstanding;
  int compared;

  bit idle_on = 1'b1;
  bit hold_request = 1'b0;
  bit hold_served = 1'b0;
  int hold_left = 0;
  int burst_left = 0;
  int cycles = 0;
  int prices_sent = 0;
  int reg_writes = 0;

  rsi_slope_trend_direction_top #(
    .MAX_WINDOW(MAX_WINDOW),
    .PRICE_BITS(32)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .price(price),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .trend_direction(trend_direction),
    .rsi_value(rsi_value),
    .smoothed_slope(smoothed_slope),
    .warmed(warmed),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  rsi_trend_checker #(
    .MAX_WINDOW(MAX_WINDOW)
  ) trend_chk (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .price(price),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .trend_direction(trend_direction),
    .rsi_value(rsi_value),
    .smoothed_slope(smoothed_slope),
    .warmed(warmed),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(mismatches),
    .outstanding(outstanding),
    .compared(compared)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold counted here.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(1, 5) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_price(input logic [31:0] px);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    price <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    prices_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
  endtask

  initial begin
    logic [31:0] probe_a [6];
    logic [31:0] probe_b [7];
    logic [31:0] px;
    logic [CFG_DATA_W-1:0] len_v;
    logic [CFG_DATA_W-1:0] wt_v;
    logic [CFG_DATA_W-1:0] thr_v;
    longint nxt;
    longint step;
    int phase;
    int span_items;
    int style;
    int bias;
    int sent;

    probe_a = '{32'd5, 32'd5, 32'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0};
    probe_b = '{32'd10, 32'd20, 32'd15, 32'd15, 32'd40, 32'd0, 32'hFFFF_FFFF};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: first price latched, then full-scale swings into a partial window.
    send_price(32'd0);
    send_price(32'hFFFF_FFFF);
    send_price(32'd0);
    send_price(32'd1);

    settle();
    write_reg(CFG_WINDOW_LENGTH, '0);
    write_reg(CFG_EMA_WEIGHT, CFG_DATA_W'(WEIGHT_ONE));
    write_reg(CFG_TREND_THRESHOLD, '0);
    cfg_valid <= 1'b0;
    foreach (probe_a[i]) send_price(probe_a[i]);

    settle();
    write_reg(CFG_WINDOW_LENGTH, CFG_DATA_W'(2));
    write_reg(CFG_EMA_WEIGHT, '0);
    write_reg(CFG_TREND_THRESHOLD, {CFG_DATA_W{1'b1}});
    cfg_valid <= 1'b0;
    foreach (probe_b[i]) send_price(probe_b[i]);

    px = 32'd5_000_000;
    sent = 0;
    phase = 0;
    while (sent < ITEMS) begin
      settle();
      if (sent > ITEMS * 7 / 8) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 3) != 0);
      case (phase)
        0: begin
          len_v = CFG_DATA_W'(16);
          wt_v = CFG_DATA_W'(WEIGHT_ONE);
          thr_v = '0;
        end
        1: begin
          len_v = CFG_DATA_W'(31);
          wt_v = CFG_DATA_W'(131071);
          thr_v = {CFG_DATA_W{1'b1}};
        end
        2: begin
          len_v = CFG_DATA_W'(1);
          wt_v = CFG_DATA_W'(1);
          thr_v = CFG_DATA_W'(RSI_FULL);
          hold_request = 1'b1;
        end
        3: begin
          len_v = CFG_DATA_W'(17);
          wt_v = '0;
          thr_v = CFG_DATA_W'(THR_RST);
        end
        default: begin
          len_v = CFG_DATA_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                          : $urandom_range(1, 16));
          case ($urandom_range(0, 7))
            0:       wt_v = '0;
            1:       wt_v = CFG_DATA_W'($urandom_range(65537, 131071));
            default: wt_v = CFG_DATA_W'($urandom_range(1, 65536));
          endcase
          if ($urandom_range(0, 3) == 0) thr_v = CFG_DATA_W'($urandom());
          else thr_v = CFG_DATA_W'($urandom_range(0, 200000));
        end
      endcase
      if (phase < 4 || $urandom_range(0, 1) == 1) write_reg(CFG_WINDOW_LENGTH, len_v);
      write_reg(CFG_EMA_WEIGHT, wt_v);
      write_reg(CFG_TREND_THRESHOLD, thr_v);
      if (phase == 3) write_reg(CFG_SPARE, CFG_DATA_W'($urandom()));
      cfg_valid <= 1'b0;

      style = $urandom_range(0, 3);
      bias = $urandom_range(15, 85);
      span_items = $urandom_range(60, 200);
      repeat (span_items) begin
        case (style)
          0: begin
            step = longint'($urandom_range(0, 3000));
            if ($urandom_range(0, 99) < bias) nxt = longint'(px) + step;
            else nxt = longint'(px) - step;
          end
          1: nxt = longint'($urandom());
          2: begin
            if ($urandom_range(0, 2) == 0) nxt = longint'(px);
            else nxt = longint'(px) + longint'($urandom_range(0, 40)) - 20;
          end
          default: begin
            if ($urandom_range(0, 1) == 1) nxt = longint'($urandom_range(0, 255));
            else nxt = longint'(32'hFFFF_FFFF) - longint'($urandom_range(0, 255));
          end
        endcase
        if (nxt < 0) nxt = 0;
        else if (nxt > longint'(32'hFFFF_FFFF)) nxt = longint'(32'hFFFF_FFFF);
        px = nxt[31:0];
        send_price(px);
        sent++;
      end
      phase++;
    end

    settle();
    repeat (TAIL) @(posedge clk);

    $display("summary: %0d prices, %0d register writes over %0d settings, %0d results compared",
             prices_sent, reg_writes, phase + 2, compared);
    $display("summary: window lengths 0 to 31, weights 0 to 131071, full-scale thresholds, %s",
             "one long output hold");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ rsi_slope_trend_direction_top.f @@
rtl/rstd_pkg.sv
rtl/rstd_ram.sv
rtl/rstd_div.sv
rtl/rstd_mul.sv
rtl/rsi_slope_trend_direction_top.sv
bench/rsi_trend_checker.sv
bench/rsi_slope_trend_direction_top_tb.sv
